>>> sv/first_fit_block_allocator_core_defines.svh
// Assertion macros shared by the allocator core RTL
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// checked outside reset
`define FFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define FFBA_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define FFBA_ASSERT(lbl, prop, msg)
`define FFBA_ASSERT_NR(lbl, prop, msg)
`endif
`endif

>>> sv/ffba_pkg.sv
// Shared types, codes and constants of the first-fit allocator
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 32;
  localparam int HEADER_BYTES   = 12;

  localparam int SIZE_W    = 24;
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIZE = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_UNKNOWN  = 2'd3
  } status_e;

  typedef struct packed {
    logic [WORD_W-1:0] heap_base;
    logic [WORD_W-1:0] heap_limit;
  } cfg_t;

endpackage

>>> sv/ffba_if.sv
// Request and response channel interfaces of the allocator
interface ffba_req_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [SIZE_W-1:0] request_size;
  logic [WORD_W-1:0] free_address;

  modport source (output valid, req_type, request_size, free_address, input ready);
  modport sink   (input valid, req_type, request_size, free_address, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_address;
  status_e           status;
  logic              reused;

  modport source (output valid, result_address, status, reused, input ready);
  modport sink   (input valid, result_address, status, reused, output ready);
endinterface

>>> sv/ffba_table.sv
// Block table memory: one write port, one registered read port
module ffba_table import ffba_pkg::*; #(
  parameter int DEPTH = MAX_BLOCKS_DEF,
  parameter int AW    = $clog2(MAX_BLOCKS_DEF),
  parameter int DW    = ADDR_BITS_DEF + SIZE_W + 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ffba_ctrl.sv
// Allocator sequencer: table scan, heap growth and result register
`include "first_fit_block_allocator_core_defines.svh"
module ffba_ctrl import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF,
  parameter int IW         = $clog2(MAX_BLOCKS),
  parameter int ENT_W      = ADDR_BITS + SIZE_W + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  ffba_req_if.sink         req,
  ffba_rsp_if.source       rsp,
  output logic             mem_re_o,
  output logic [IW-1:0]    mem_raddr_o,
  input  logic [ENT_W-1:0] mem_rdata_i,
  output logic             mem_we_o,
  output logic [IW-1:0]    mem_waddr_o,
  output logic [ENT_W-1:0] mem_wdata_o
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int MW    = (ADDR_BITS > WORD_W) ? ADDR_BITS : WORD_W;
  localparam int SW    = MW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_GROW  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]           st_q, st_d;
  logic                 type_q, type_d;
  logic [SIZE_W-1:0]    size_q, size_d;
  logic [WORD_W-1:0]    faddr_q, faddr_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [ADDR_BITS-1:0] top_q, top_d;
  logic [SW-1:0]        sum_q, sum_d;
  logic [ADDR_BITS-1:0] pay_q, pay_d;
  logic [WORD_W-1:0]    res_addr_q, res_addr_d;
  status_e              res_st_q, res_st_d;
  logic                 res_reu_q, res_reu_d;
  logic                 o_vld_q, o_vld_d;
  logic [WORD_W-1:0]    o_addr_q;
  status_e              o_st_q;
  logic                 o_reu_q;
  logic                 load;

  logic [ADDR_BITS-1:0] rd_pay;
  logic [SIZE_W-1:0]    rd_size;
  logic                 rd_free;
  logic [63:0]          rd_pay64, pay64;
  logic                 hit, last, grow_fail;
  logic [ADDR_BITS-1:0] top_sel;

  assign rd_pay   = mem_rdata_i[ENT_W-1 -: ADDR_BITS];
  assign rd_size  = mem_rdata_i[SIZE_W:1];
  assign rd_free  = mem_rdata_i[0];
  assign rd_pay64 = 64'(rd_pay);
  assign pay64    = 64'(pay_q);

  // payload addresses are stored already masked, so a free compares directly
  assign hit  = (type_q == REQ_ALLOC) ? (rd_free && (rd_size >= size_q))
                                      : (MW'(rd_pay) == MW'(faddr_q));
  assign last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));

  assign top_sel   = (count_q == '0) ? ADDR_BITS'(cfg_i.heap_base) : top_q;
  assign grow_fail = (|sum_q[SW-1:ADDR_BITS]) || (sum_q > SW'(cfg_i.heap_limit));

  always_comb begin
    st_d        = st_q;
    type_d      = type_q;
    size_d      = size_q;
    faddr_d     = faddr_q;
    idx_d       = idx_q;
    count_d     = count_q;
    top_d       = top_q;
    sum_d       = sum_q;
    pay_d       = pay_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    res_reu_d   = res_reu_q;
    load        = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = (st_q == S_IDLE) ? '0 : idx_q + IW'(1);
    mem_we_o    = 1'b0;
    mem_waddr_o = idx_q;
    mem_wdata_o = {rd_pay, rd_size, type_q == REQ_FREE};

    unique case (st_q)
      S_IDLE: begin
        if (req.valid) begin
          type_d     = req.req_type;
          size_d     = req.request_size;
          faddr_d    = req.free_address;
          idx_d      = '0;
          res_addr_d = '0;
          res_st_d   = ST_OK;
          res_reu_d  = 1'b0;
          if (req.req_type == REQ_ALLOC && req.request_size == '0) begin
            res_st_d = ST_BAD_SIZE;
            st_d     = S_RESP;
          end else if (req.req_type == REQ_FREE && req.free_address == '0) begin
            st_d = S_RESP;
          end else if (count_q == '0) begin
            if (req.req_type == REQ_ALLOC) begin
              st_d = S_GROW;
            end else begin
              res_st_d = ST_UNKNOWN;
              st_d     = S_RESP;
            end
          end else begin
            mem_re_o = 1'b1;
            st_d     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          // rewrite the entry with the new free mark
          mem_we_o = 1'b1;
          if (type_q == REQ_ALLOC) begin
            res_addr_d = rd_pay64[WORD_W-1:0];
            res_reu_d  = 1'b1;
          end
          st_d = S_RESP;
        end else if (last) begin
          if (type_q == REQ_ALLOC) begin
            st_d = S_GROW;
          end else begin
            res_st_d = ST_UNKNOWN;
            st_d     = S_RESP;
          end
        end else begin
          mem_re_o = 1'b1;
          idx_d    = idx_q + IW'(1);
        end
      end
      S_GROW: begin
        if (count_q == CNT_W'(MAX_BLOCKS)) begin
          res_st_d = ST_NO_SPACE;
          st_d     = S_RESP;
        end else begin
          sum_d = SW'(top_sel) + SW'(size_q) + SW'(HEADER_BYTES);
          pay_d = top_sel + ADDR_BITS'(HEADER_BYTES);
          st_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (grow_fail) begin
          res_st_d = ST_NO_SPACE;
        end else begin
          mem_we_o    = 1'b1;
          mem_waddr_o = count_q[IW-1:0];
          mem_wdata_o = {pay_q, size_q, 1'b0};
          count_d     = count_q + CNT_W'(1);
          top_d       = sum_q[ADDR_BITS-1:0];
          res_addr_d  = pay64[WORD_W-1:0];
        end
        st_d = S_RESP;
      end
      S_RESP: begin
        if (!o_vld_q || rsp.ready) begin
          load = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  assign o_vld_d = load ? 1'b1 : (o_vld_q && !rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      count_q <= '0;
      top_q   <= '0;
      o_vld_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_d;
      top_q   <= top_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    size_q     <= size_d;
    faddr_q    <= faddr_d;
    idx_q      <= idx_d;
    sum_q      <= sum_d;
    pay_q      <= pay_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    res_reu_q  <= res_reu_d;
    if (load) begin
      o_addr_q <= res_addr_q;
      o_st_q   <= res_st_q;
      o_reu_q  <= res_reu_q;
    end
  end

  assign req.ready          = (st_q == S_IDLE);
  assign rsp.valid          = o_vld_q;
  assign rsp.result_address = o_addr_q;
  assign rsp.status         = o_st_q;
  assign rsp.reused         = o_reu_q;

  `FFBA_ASSERT(a_we_state, mem_we_o |-> (st_q == S_SCAN || st_q == S_CHECK), "table write outside scan or grow")
  `FFBA_ASSERT(a_idx_range, (st_q == S_SCAN) |-> (CNT_W'(idx_q) < count_q), "scan index past block count")
  `FFBA_ASSERT(a_cnt_step, (count_q != $past(count_q)) |-> ($past(st_q) == S_CHECK), "block count moved outside growth")
  `FFBA_ASSERT(a_one_item, (req.valid && req.ready) |=> !req.ready, "second beat taken while busy")
  `FFBA_ASSERT_NR(a_rst_quiet, !rst_ni |-> !rsp.valid, "response valid during reset")

endmodule

>>> sv/first_fit_block_allocator_core.sv
// Top level of the first-fit block allocator: config registers, sequencer, block table
//
//  channel  dir  handshake      payload
//  req_i    in   valid/ready    req_type, request_size, free_address
//  rsp_o    out  valid/ready    result_address, status, reused
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i (0 heap_base, 1 heap_limit)
//
// One request at a time. The scan over the block table read port checks one entry per cycle.
// Table contents are undefined after reset; only entries below the block count are read,
// so no clearing pass is run. A result held in the output register does not block the
// next request beat.
module first_fit_block_allocator_core import ffba_pkg::*; #(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_W-1:0]    cfg_wdata_i,
  ffba_req_if.sink             req_i,
  ffba_rsp_if.source           rsp_o
);

  localparam int IW    = $clog2(MAX_BLOCKS);
  localparam int ENT_W = ADDR_BITS + SIZE_W + 1;

  cfg_t cfg_q, cfg_d;

  logic             mem_re, mem_we;
  logic [IW-1:0]    mem_raddr, mem_waddr;
  logic [ENT_W-1:0] mem_rdata, mem_wdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAP_BASE:  cfg_d.heap_base  = cfg_wdata_i;
        CFG_HEAP_LIMIT: cfg_d.heap_limit = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heap_base  <= '0;
      cfg_q.heap_limit <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ffba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS),
    .IW         (IW),
    .ENT_W      (ENT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req         (req_i),
    .rsp         (rsp_o),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  ffba_table #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IW),
    .DW    (ENT_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
